>>> rtl/core/edge_level_interrupt_controller_defines.svh
// ----------------------------------------------------------------------------
// edge_level_interrupt_controller_defines
// assertion macros used by the interrupt controller top level
// ----------------------------------------------------------------------------
`ifndef EDGE_LEVEL_INTERRUPT_CONTROLLER_DEFINES_SVH
`define EDGE_LEVEL_INTERRUPT_CONTROLLER_DEFINES_SVH

// checked outside reset only
`define ELIC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define ELIC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/core/elic_pkg.sv
// ----------------------------------------------------------------------------
// elic_pkg
// types and constants of the edge/level interrupt controller
// ----------------------------------------------------------------------------
`default_nettype none

package elic_pkg;

  localparam int unsigned NumLines = 32;
  localparam int unsigned WordW    = 32;
  localparam int unsigned LineIdxW = 5;

  // bits above NumLines are held at zero
  localparam logic [WordW-1:0] LineMask = WordW'((64'd1 << NumLines) - 64'd1);

  typedef enum logic [1:0] {
    CmdRead  = 2'd0,
    CmdWrite = 2'd1,
    CmdLine  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    RegStatus   = 3'd0,
    RegEnable   = 3'd1,
    RegSet      = 3'd2,
    RegClear    = 3'd3,
    RegPolarity = 3'd4,
    RegEdge     = 3'd5
  } reg_e;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [2:0]          reg_index;
    logic [WordW-1:0]    write_data;
    logic [LineIdxW-1:0] line;
    logic                level;
  } in_item_t;

  typedef struct packed {
    logic [WordW-1:0] read_data;
    logic             irq_out;
  } out_item_t;

endpackage

`default_nettype wire

>>> rtl/core/elic_in_stage.sv
// ----------------------------------------------------------------------------
// elic_in_stage
// input register: holds one accepted item until the core consumes it
// ----------------------------------------------------------------------------
`default_nettype none

module elic_in_stage import elic_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  in_item_t      in_item_i,
  input  wire logic     take_i,
  output logic          full_o,
  output in_item_t      item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;

  assign in_ready_o = !valid_q || take_i;
  assign valid_d    = (in_valid_i && in_ready_o) || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

  assign full_o = valid_q;
  assign item_o = item_q;

endmodule

`default_nettype wire

>>> rtl/core/elic_core.sv
// ----------------------------------------------------------------------------
// elic_core
// interrupt state registers, register file access and line handling
// ----------------------------------------------------------------------------
`default_nettype none

module elic_core import elic_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  in_item_t   item_i,
  input  wire logic  upd_i,
  output out_item_t  res_o,
  output logic       irq_state_o
);

  logic [WordW-1:0] pending_q, pending_d;
  logic [WordW-1:0] enable_q, enable_d;
  logic [WordW-1:0] polarity_q, polarity_d;
  logic [WordW-1:0] edge_q, edge_d;
  logic [WordW-1:0] wdata;
  logic [WordW-1:0] line_bit;
  logic [WordW-1:0] rdata;
  logic             line_ok;

  assign wdata    = item_i.write_data & LineMask;
  assign line_bit = WordW'(1) << item_i.line;
  assign line_ok  = 32'(item_i.line) < NumLines;

  always_comb begin
    pending_d  = pending_q;
    enable_d   = enable_q;
    polarity_d = polarity_q;
    edge_d     = edge_q;
    rdata      = '0;
    case (item_i.cmd)
      CmdRead: begin
        case (item_i.reg_index)
          RegStatus:   rdata = pending_q & enable_q;
          RegEnable:   rdata = enable_q;
          RegPolarity: rdata = polarity_q;
          RegEdge:     rdata = edge_q;
          default:     rdata = '0;
        endcase
      end
      CmdWrite: begin
        case (item_i.reg_index)
          RegStatus:   pending_d  = wdata;
          RegEnable:   enable_d   = wdata;
          RegSet:      enable_d   = enable_q | wdata;
          // the clear register clears only edge-type lines
          RegClear:    pending_d  = pending_q & ~(wdata & edge_q);
          RegPolarity: polarity_d = wdata;
          RegEdge:     edge_d     = wdata;
          default:     ;
        endcase
      end
      CmdLine: begin
        if (line_ok) begin
          if (item_i.level) begin
            pending_d = (pending_q | line_bit) & LineMask;
          end else begin
            // a falling level-type line drops its pending bit
            pending_d = pending_q & (~line_bit | edge_q) & LineMask;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q  <= '0;
      enable_q   <= '0;
      polarity_q <= '0;
      edge_q     <= '0;
    end else if (upd_i) begin
      pending_q  <= pending_d;
      enable_q   <= enable_d;
      polarity_q <= polarity_d;
      edge_q     <= edge_d;
    end
  end

  assign res_o.read_data = rdata;
  assign res_o.irq_out   = |(pending_d & enable_d);
  assign irq_state_o     = |(pending_q & enable_q);

endmodule

`default_nettype wire

>>> rtl/core/elic_out_stage.sv
// ----------------------------------------------------------------------------
// elic_out_stage
// result register towards the consumer
// ----------------------------------------------------------------------------
`default_nettype none

module elic_out_stage import elic_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  load_i,
  input  out_item_t  res_i,
  output logic       space_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output out_item_t  out_item_o
);

  logic      valid_q, valid_d;
  out_item_t item_q;

  assign space_o = !valid_q || out_ready_i;
  assign valid_d = load_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

`default_nettype wire

>>> rtl/core/edge_level_interrupt_controller.sv
// ----------------------------------------------------------------------------
// edge_level_interrupt_controller
// 32-line interrupt controller with edge and level line types
// ----------------------------------------------------------------------------
// Takes one item per clock unless the result register is full and not taken:
// a register read, a register write or a new level on one interrupt line, and
// returns one result per item holding the read data and the irq level after
// that item. An accepted item is held in the input register, is applied to
// the state registers by combinational logic as it leaves, and its result is
// held in the result register until the consumer takes it. One item per
// cycle is sustained while the consumer keeps taking results.
// ----------------------------------------------------------------------------
`default_nettype none

`include "edge_level_interrupt_controller_defines.svh"

module edge_level_interrupt_controller import elic_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  in_item_t   in_item_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output out_item_t  out_item_o
);

  logic       in_full;
  logic       out_space;
  in_item_t   cur_item;
  out_item_t  res;
  logic       advance;
  logic       irq_state;

  assign advance = in_full && out_space;

  elic_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .take_i     (advance),
    .full_o     (in_full),
    .item_o     (cur_item)
  );

  elic_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (cur_item),
    .upd_i       (advance),
    .res_o       (res),
    .irq_state_o (irq_state)
  );

  elic_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .res_i       (res),
    .space_o     (out_space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  `ELIC_ASSERT(a_irq_matches_state, advance |=> out_item_o.irq_out == irq_state, "irq result differs from state")
  `ELIC_ASSERT(a_result_from_item, $rose(out_valid_o) |-> $past(in_full), "result without an item")
  `ELIC_ASSERT(a_stall_only_when_blocked, !in_ready_o |-> in_full && !out_space, "input stalled without cause")
  `ELIC_ASSERT_ALWAYS(a_no_result_in_reset, !rst_ni |-> !out_valid_o, "result valid during reset")

endmodule

`default_nettype wire
